// ----- sv/imsp_pkg.sv -----
`timescale 1ns / 1ps
package imsp_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ANGLE  = 8'h01;
  localparam logic [7:0] TYPE_MOTION = 8'h03;

  localparam int ANGLE_NEED        = 6;
  localparam int MOTION_NEED       = 12;
  localparam int CAPTURE_BYTES_DEF = 12;
  localparam int NUM_WORDS         = 6;
  localparam int WORD_W            = 16;
  localparam int VALUE_W           = 28;
  localparam int ACCEL_W           = 8;
  localparam int GYRO_W            = 12;
  localparam int COUNT_W           = 32;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [ACCEL_W-1:0] ACCEL_RESET = 8'd16;
  localparam logic [GYRO_W-1:0]  GYRO_RESET  = 12'd2000;
  localparam logic [GYRO_W-1:0]  ANGLE_SCALE = 12'd180;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 2'd1;

  typedef enum logic [1:0] {
    ST_ANGLE     = 2'd0,
    ST_MOTION    = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_BAD_FRAME = 2'd3
  } status_t;

  typedef struct packed {
    status_t                          status;
    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    logic [COUNT_W-1:0]               good_frames;
  } job_t;

endpackage

// ----- sv/imsp_ifs.sv -----
`timescale 1ns / 1ps
interface imsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_start;
  modport source(output valid, rx_byte, buffer_start, input ready);
  modport sink(input valid, rx_byte, buffer_start, output ready);
endinterface

interface imsp_out_if import imsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                frame_status;
  logic signed [VALUE_W-1:0] value_a;
  logic signed [VALUE_W-1:0] value_b;
  logic signed [VALUE_W-1:0] value_c;
  logic signed [VALUE_W-1:0] value_d;
  logic signed [VALUE_W-1:0] value_e;
  logic signed [VALUE_W-1:0] value_f;
  logic [COUNT_W-1:0]        good_frames;
  modport source(output valid, frame_status, value_a, value_b, value_c, value_d, value_e,
                 value_f, good_frames, input ready);
  modport sink(input valid, frame_status, value_a, value_b, value_c, value_d, value_e,
               value_f, good_frames, output ready);
endinterface

interface imsp_cfg_if import imsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/imu_sum_checked_frame_parser.sv -----
`timescale 1ns / 1ps
// imu serial frame parser with 8-bit sum check
// in_ch takes one receive byte per item with a buffer-start flag; a frame
// (0x55 0x55, type, length, data, checksum) must open a buffer.
// out_ch gives one item per frame at its checksum byte: status, six scaled
// values in units of 1/32768 and the count of good frames.
// cfg_ch writes accel_range (index 0) and gyro_range (index 1); ready is
// always high, and writes belong in idle time.
// throughput: one byte per cycle while the job queue is not full; the
// parser classifies each byte in the cycle it is taken.
// path: a result goes from its checksum byte into the two-entry job queue,
// then through the scaling multipliers into the output register.
// stall: a held output keeps its item while the queue fills; in_ch.ready
// drops only when the queue is full.
// reset: counters and parse state clear, ranges return to 16 and 2000,
// and bytes are ignored until the next buffer start.
module imu_sum_checked_frame_parser import imsp_pkg::*; #(
  parameter int CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  imsp_in_if.sink    in_ch,
  imsp_out_if.source out_ch,
  imsp_cfg_if.sink   cfg_ch
);

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_valid;
  job_t q_head_job;
  logic q_pop;

  imsp_front #(
    .CAPTURE_BYTES(CAPTURE_BYTES)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_full(q_full),
    .q_push(q_push),
    .q_job (q_push_job)
  );

  imsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .head_valid(q_valid),
    .head_job  (q_head_job),
    .pop       (q_pop)
  );

  imsp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch),
    .q_valid(q_valid),
    .q_job  (q_head_job),
    .q_pop  (q_pop)
  );

endmodule

// ----- sv/imsp_front.sv -----
`timescale 1ns / 1ps
module imsp_front import imsp_pkg::*; #(
  parameter int CAPTURE_BYTES = CAPTURE_BYTES_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  imsp_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output job_t   q_job
);

  localparam int CAP_IDX_W = $clog2(CAPTURE_BYTES);

  logic [8:0]         pos_r, pos_nxt;
  logic [7:0]         len_r, len_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic               done_r, done_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [7:0]         cap_r [CAPTURE_BYTES];

  logic                             accept;
  logic [8:0]                       cur_pos;
  logic [7:0]                       cur_len;
  logic [7:0]                       cur_type;
  logic [7:0]                       cur_sum;
  logic                             cur_done;
  logic [8:0]                       idx;
  logic                             cap_we;
  logic                             too_short;
  logic [NUM_WORDS-1:0][WORD_W-1:0] raw_w;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx         = cur_pos - 9'd4;

  // little-endian words from the capture registers
  for (genvar k = 0; k < NUM_WORDS; k++) begin : g_word
    if (2 * k + 1 < CAPTURE_BYTES) begin : g_in
      assign raw_w[k] = {cap_r[2*k+1], cap_r[2*k]};
    end else begin : g_out
      assign raw_w[k] = '0;
    end
  end

  always_comb begin
    cur_pos  = in_ch.buffer_start ? 9'd0 : pos_r;
    cur_len  = in_ch.buffer_start ? 8'd0 : len_r;
    cur_type = in_ch.buffer_start ? 8'd0 : type_r;
    cur_sum  = in_ch.buffer_start ? 8'd0 : sum_r;
    cur_done = in_ch.buffer_start ? 1'b0 : done_r;

    pos_nxt   = pos_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    sum_nxt   = sum_r;
    done_nxt  = done_r;
    count_nxt = count_r;
    cap_we    = 1'b0;
    q_push    = 1'b0;
    q_job     = '0;

    if (cur_type == TYPE_ANGLE) begin
      too_short = ({24'd0, cur_len} < ANGLE_NEED) || (ANGLE_NEED > CAPTURE_BYTES);
    end else begin
      too_short = ({24'd0, cur_len} < MOTION_NEED) || (MOTION_NEED > CAPTURE_BYTES);
    end

    if (accept) begin
      pos_nxt  = cur_pos + 9'd1;
      len_nxt  = cur_len;
      type_nxt = cur_type;
      sum_nxt  = cur_sum + in_ch.rx_byte;
      done_nxt = cur_done;
      if (!cur_done) begin
        if (cur_pos < 9'd2) begin
          if (in_ch.rx_byte != SYNC_BYTE) begin
            done_nxt = 1'b1;
            pos_nxt  = cur_pos;
            sum_nxt  = cur_sum;
          end
        end else if (cur_pos == 9'd2) begin
          type_nxt = in_ch.rx_byte;
        end else if (cur_pos == 9'd3) begin
          len_nxt = in_ch.rx_byte;
        end else if (cur_pos < {1'b0, cur_len} + 9'd4) begin
          cap_we = (idx < 9'(CAPTURE_BYTES));
        end else begin
          // checksum byte ends the frame
          done_nxt = 1'b1;
          pos_nxt  = cur_pos;
          sum_nxt  = cur_sum;
          q_push   = 1'b1;
          if (!(cur_type inside {TYPE_ANGLE, TYPE_MOTION})) begin
            q_job.status = ST_BAD_FRAME;
          end else if (cur_sum != in_ch.rx_byte) begin
            q_job.status = ST_BAD_SUM;
          end else if (too_short) begin
            q_job.status = ST_BAD_FRAME;
          end else if (cur_type == TYPE_ANGLE) begin
            q_job.status   = ST_ANGLE;
            q_job.words[0] = raw_w[0];
            q_job.words[1] = raw_w[1];
            q_job.words[2] = raw_w[2];
            count_nxt      = count_r + 1'b1;
          end else begin
            q_job.status = ST_MOTION;
            q_job.words  = raw_w;
            count_nxt    = count_r + 1'b1;
          end
        end
      end else begin
        pos_nxt = cur_pos;
        sum_nxt = cur_sum;
      end
    end
    q_job.good_frames = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      len_r   <= '0;
      type_r  <= '0;
      sum_r   <= '0;
      done_r  <= 1'b1;
      count_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      type_r  <= type_nxt;
      sum_r   <= sum_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap_we) begin
      cap_r[idx[CAP_IDX_W-1:0]] <= in_ch.rx_byte;
    end
  end

endmodule

// ----- sv/imsp_queue.sv -----
`timescale 1ns / 1ps
module imsp_queue import imsp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

endmodule

// ----- sv/imsp_back.sv -----
`timescale 1ns / 1ps
module imsp_back import imsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  imsp_cfg_if.sink    cfg_ch,
  imsp_out_if.source  out_ch,
  input  logic        q_valid,
  input  job_t        q_job,
  output logic        q_pop
);

  function automatic logic [VALUE_W-1:0] scale(input logic [WORD_W-1:0] w,
                                               input logic [GYRO_W-1:0] m);
    logic signed [VALUE_W:0] p;
    p = $signed(w) * $signed({1'b0, m});
    return p[VALUE_W-1:0];
  endfunction

  logic [ACCEL_W-1:0] accel_r;
  logic [GYRO_W-1:0]  gyro_r;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r;
  logic [VALUE_W-1:0] val_r [NUM_WORDS];
  logic [COUNT_W-1:0] good_r;

  logic               load;
  logic [GYRO_W-1:0]  mul_abc;

  assign cfg_ch.ready = 1'b1;

  assign load    = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop   = load;
  assign mul_abc = (q_job.status == ST_ANGLE) ? ANGLE_SCALE : {{(GYRO_W-ACCEL_W){1'b0}}, accel_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r     <= ACCEL_RESET;
      gyro_r      <= GYRO_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_ACCEL_RANGE: accel_r <= cfg_ch.data[ACCEL_W-1:0];
          REG_GYRO_RANGE:  gyro_r  <= cfg_ch.data[GYRO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // words of non-decoded frames arrive as zero, so products are zero too
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= q_job.status;
      good_r   <= q_job.good_frames;
      for (int k = 0; k < NUM_WORDS; k++) begin
        val_r[k] <= scale(q_job.words[k], (k < 3) ? mul_abc : gyro_r);
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_status = status_r;
  assign out_ch.value_a      = val_r[0];
  assign out_ch.value_b      = val_r[1];
  assign out_ch.value_c      = val_r[2];
  assign out_ch.value_d      = val_r[3];
  assign out_ch.value_e      = val_r[4];
  assign out_ch.value_f      = val_r[5];
  assign out_ch.good_frames  = good_r;

endmodule
